[hdl/sfcs_pkg.sv]
// Shared constants, types and codes for the SPI flash command sequencer.
package sfcs_pkg;

    // Flash geometry and request limits. Page and sector sizes must be powers of two.
    localparam int FLASH_BYTES       = 1048576;
    localparam int PAGE_BYTES        = 256;
    localparam int SECTOR_BYTES      = 4096;
    localparam int MAX_REQUEST_BYTES = 15872;
    localparam int MAX_RESULTS       = 64;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 24;
    localparam int LEN_W    = 24;
    localparam int BUF_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OPC_W    = 8;
    localparam int HDR_W    = 3;
    localparam int DIR_W    = 2;
    localparam int DBYTES_W = 14;

    // Derived widths and masks.
    localparam int PAGE_LG   = $clog2(PAGE_BYTES);
    localparam int SECTOR_LG = $clog2(SECTOR_BYTES);
    localparam int CHUNK_W   = PAGE_LG + 1;
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int SPAN_W    = LEN_W + 1;

    localparam logic [LEN_W-1:0]  MAX_LEN     = LEN_W'(MAX_REQUEST_BYTES);
    localparam logic [ADDR_W-1:0] PAGE_MASK   = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'(SECTOR_BYTES - 1);

    // Plan queue depth between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_SFDP  = 3'd1;
    localparam logic [OP_W-1:0] OP_ID    = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd4;
    localparam logic [OP_W-1:0] OP_SLEEP = 3'd5;
    localparam logic [OP_W-1:0] OP_WAKE  = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_READ_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERASE_BAD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd3;

    // SPI command bytes.
    localparam logic [OPC_W-1:0] OPC_PAGE_PROGRAM = 8'h02;
    localparam logic [OPC_W-1:0] OPC_READ         = 8'h03;
    localparam logic [OPC_W-1:0] OPC_SECTOR_ERASE = 8'h20;
    localparam logic [OPC_W-1:0] OPC_READ_SFDP    = 8'h5a;
    localparam logic [OPC_W-1:0] OPC_READ_ID      = 8'h90;
    localparam logic [OPC_W-1:0] OPC_WAKE         = 8'hab;
    localparam logic [OPC_W-1:0] OPC_SLEEP        = 8'hb9;

    // Header lengths.
    localparam logic [HDR_W-1:0] HDR_OPCODE = 3'd1;
    localparam logic [HDR_W-1:0] HDR_ADDR   = 3'd4;
    localparam logic [HDR_W-1:0] HDR_DUMMY  = 3'd5;

    // Payload directions.
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_READ  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_WRITE = 2'd2;

    // What the back has to produce after an optional wake command.
    typedef enum logic [2:0] {
        PLAN_ERROR,
        PLAN_NONE,
        PLAN_READ,
        PLAN_WRITE,
        PLAN_ERASE,
        PLAN_SLEEP
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t            kind;
        logic                  wake;
        logic [STATUS_W-1:0]   status;
        logic [OPC_W-1:0]      opcode;
        logic [HDR_W-1:0]      hdr;
        logic [ADDR_W-1:0]     addr;
        logic [DBYTES_W-1:0]   len;
        logic [BUF_W-1:0]      buf_base;
        logic [CNT_W-1:0]      cnt;
    } plan_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                issue;
        logic                poll_before;
        logic                write_enable;
        logic [OPC_W-1:0]    opcode;
        logic [HDR_W-1:0]    header_bytes;
        logic [ADDR_W-1:0]   cmd_addr;
        logic [DIR_W-1:0]    data_dir;
        logic [DBYTES_W-1:0] data_bytes;
        logic [BUF_W-1:0]    buffer_pos;
        logic                poll_after;
        logic                last;
    } desc_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WAKE,
        SEQ_BODY
    } seq_state_t;

endpackage

[hdl/spi_flash_command_sequencer.sv]
// Top level of the SPI flash command sequencer: front end, plan queue and sequencer.
//
// Channel      Direction  Handshake            Transaction
// request      in         push / full          operation, flash_addr, byte_count, buffer_addr
// descriptor   out        empty / pop          one SPI command descriptor, last marks the end
//
// A request is checked and classified in the cycle it is accepted and lands in a two-entry
// plan queue. The sequencer takes a plan from the queue while idle and then emits its
// descriptors in order, from 1 to 64 per request, each one as the output register frees.
// Reset clears the power state to asleep and empties the queue and the output register.
// A stalled pop holds the current descriptor; the sequencer waits, and the front end keeps
// taking requests until the plan queue is full.
module spi_flash_command_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [sfcs_pkg::OP_W-1:0]       operation,
    input  logic [sfcs_pkg::ADDR_W-1:0]     flash_addr,
    input  logic [sfcs_pkg::LEN_W-1:0]      byte_count,
    input  logic [sfcs_pkg::BUF_W-1:0]      buffer_addr,
    output logic                            empty,
    input  logic                            pop,
    output logic [sfcs_pkg::STATUS_W-1:0]   status,
    output logic                            issue,
    output logic                            poll_before,
    output logic                            write_enable,
    output logic [sfcs_pkg::OPC_W-1:0]      opcode,
    output logic [sfcs_pkg::HDR_W-1:0]      header_bytes,
    output logic [sfcs_pkg::ADDR_W-1:0]     cmd_addr,
    output logic [sfcs_pkg::DIR_W-1:0]      data_dir,
    output logic [sfcs_pkg::DBYTES_W-1:0]   data_bytes,
    output logic [sfcs_pkg::BUF_W-1:0]      buffer_pos,
    output logic                            poll_after,
    output logic                            last
);
    import sfcs_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    plan_t front_plan;
    plan_t head_plan;
    logic  out_valid;
    desc_t out_desc;

    // The front end owns the power state, so wake and sleep decisions follow request order.
    sfcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .q_full      (q_full),
        .operation   (operation),
        .flash_addr  (flash_addr),
        .byte_count  (byte_count),
        .buffer_addr (buffer_addr),
        .q_push      (q_push),
        .plan        (front_plan)
    );

    sfcs_plan_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_plan (front_plan),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_plan (head_plan),
        .q_empty (q_empty)
    );

    // The sequencer keeps the finished descriptor in its output register until it is popped.
    sfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_plan    (head_plan),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .out_desc  (out_desc)
    );

    assign full         = q_full;
    assign empty        = !out_valid;
    assign status       = out_desc.status;
    assign issue        = out_desc.issue;
    assign poll_before  = out_desc.poll_before;
    assign write_enable = out_desc.write_enable;
    assign opcode       = out_desc.opcode;
    assign header_bytes = out_desc.header_bytes;
    assign cmd_addr     = out_desc.cmd_addr;
    assign data_dir     = out_desc.data_dir;
    assign data_bytes   = out_desc.data_bytes;
    assign buffer_pos   = out_desc.buffer_pos;
    assign poll_after   = out_desc.poll_after;
    assign last         = out_desc.last;

    // A descriptor that carries no command is always the final one of its request.
    a_no_issue_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !issue) |-> last)
        else $error("descriptor without a command is not marked last");

    // Error status never comes with a command to send.
    a_error_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (!issue && last))
        else $error("error descriptor carries a command");

    // Every page program moves at least one byte and never crosses a page boundary.
    a_page_program: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && issue && opcode == OPC_PAGE_PROGRAM) |->
        (data_bytes != '0 && write_enable && poll_before && data_dir == DIR_WRITE
         && (32'(cmd_addr & PAGE_MASK) + 32'(data_bytes)) <= 32'(PAGE_BYTES)))
        else $error("page program descriptor is malformed");

endmodule

[hdl/sfcs_front.sv]
// Request front end: checks and classifies each request and tracks the flash power state.
module sfcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          q_full,
    input  logic [sfcs_pkg::OP_W-1:0]     operation,
    input  logic [sfcs_pkg::ADDR_W-1:0]   flash_addr,
    input  logic [sfcs_pkg::LEN_W-1:0]    byte_count,
    input  logic [sfcs_pkg::BUF_W-1:0]    buffer_addr,
    output logic                          q_push,
    output sfcs_pkg::plan_t               plan
);
    import sfcs_pkg::*;

    logic              powered_reg;
    logic              powered_next;
    logic [OPC_W-1:0]  rd_opc;
    logic [HDR_W-1:0]  rd_hdr;
    logic [ADDR_W-1:0] rd_addr;
    logic [LEN_W-1:0]  rd_len;
    logic [SPAN_W-1:0] rd_end;
    logic [SPAN_W-1:0] wr_chunks;
    logic [SPAN_W-1:0] er_secs;
    logic [SPAN_W-1:0] er_cap;
    logic              er_bad;
    logic              asleep;

    assign q_push = push && !q_full;
    assign asleep = !powered_reg;

    always_comb
    begin
        rd_opc  = OPC_READ;
        rd_hdr  = HDR_ADDR;
        rd_addr = flash_addr;
        rd_len  = byte_count;
        if (operation == OP_SFDP)
        begin
            rd_opc  = OPC_READ_SFDP;
            rd_hdr  = HDR_DUMMY;
            rd_addr = '0;
        end
        else if (operation == OP_ID)
        begin
            rd_opc  = OPC_READ_ID;
            rd_addr = '0;
            rd_len  = LEN_W'(2);
        end
        rd_end = {1'b0, rd_addr} + {1'b0, rd_len};
    end

    // Page programs needed: bytes from the start of the first page, rounded up to pages.
    assign wr_chunks = (SPAN_W'(flash_addr & PAGE_MASK) + {1'b0, byte_count}
                        + SPAN_W'(PAGE_BYTES - 1)) >> PAGE_LG;
    assign er_secs   = ({1'b0, byte_count} + SPAN_W'(SECTOR_BYTES - 1)) >> SECTOR_LG;
    assign er_cap    = SPAN_W'(MAX_RESULTS) - SPAN_W'(asleep);
    assign er_bad    = ((flash_addr & SECTOR_MASK) != '0)
                    || ({1'b0, flash_addr} > SPAN_W'(FLASH_BYTES - SECTOR_BYTES));

    always_comb
    begin
        plan          = '0;
        plan.kind     = PLAN_ERROR;
        plan.status   = ST_OK;
        plan.addr     = flash_addr;
        plan.buf_base = buffer_addr;
        plan.len      = byte_count[DBYTES_W-1:0];
        powered_next  = powered_reg;
        case (operation)
            OP_READ, OP_SFDP, OP_ID:
            begin
                if (rd_len > MAX_LEN)
                begin
                    plan.status = ST_TOO_LONG;
                end
                else if (rd_end > SPAN_W'(FLASH_BYTES))
                begin
                    plan.status = ST_READ_RANGE;
                end
                else
                begin
                    plan.kind    = PLAN_READ;
                    plan.wake    = asleep;
                    plan.opcode  = rd_opc;
                    plan.hdr     = rd_hdr;
                    plan.addr    = rd_addr;
                    plan.len     = rd_len[DBYTES_W-1:0];
                    powered_next = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (byte_count > MAX_LEN)
                begin
                    plan.status = ST_TOO_LONG;
                end
                else if (byte_count == '0)
                begin
                    plan.status = ST_OK;
                end
                else if ((wr_chunks + SPAN_W'(asleep)) > SPAN_W'(MAX_RESULTS))
                begin
                    plan.status = ST_TOO_LONG;
                end
                else
                begin
                    plan.kind    = PLAN_WRITE;
                    plan.wake    = asleep;
                    powered_next = 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (byte_count > MAX_LEN)
                begin
                    plan.status = ST_TOO_LONG;
                end
                else
                begin
                    plan.wake    = asleep;
                    powered_next = 1'b1;
                    if (er_bad)
                    begin
                        plan.status = ST_ERASE_BAD;
                    end
                    else if (er_secs == '0)
                    begin
                        plan.kind = asleep ? PLAN_NONE : PLAN_ERROR;
                    end
                    else
                    begin
                        plan.kind = PLAN_ERASE;
                        plan.cnt  = (er_secs > er_cap) ? CNT_W'(er_cap) : CNT_W'(er_secs);
                    end
                end
            end
            OP_SLEEP:
            begin
                if (powered_reg)
                begin
                    plan.kind    = PLAN_SLEEP;
                    powered_next = 1'b0;
                end
            end
            OP_WAKE:
            begin
                if (asleep)
                begin
                    plan.kind    = PLAN_NONE;
                    plan.wake    = 1'b1;
                    powered_next = 1'b1;
                end
            end
            default:
            begin
                plan.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powered_reg <= 1'b0;
        end
        else if (q_push)
        begin
            powered_reg <= powered_next;
        end
    end

endmodule

[hdl/sfcs_plan_queue.sv]
// Short queue of classified requests between the front end and the sequencer.
module sfcs_plan_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  sfcs_pkg::plan_t wr_plan,
    output logic            q_full,
    input  logic            rd_en,
    output sfcs_pkg::plan_t rd_plan,
    output logic            q_empty
);
    import sfcs_pkg::*;

    plan_t             store_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_plan = store_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_mem[wr_ptr_reg] <= wr_plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/sfcs_back.sv]
// Command sequencer: expands each plan into SPI command descriptors, one per cycle while the output is free.
module sfcs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  sfcs_pkg::plan_t q_plan,
    output logic            q_pop,
    input  logic            pop,
    output logic            out_valid,
    output sfcs_pkg::desc_t out_desc
);
    import sfcs_pkg::*;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    plan_t               plan_reg;
    plan_t               plan_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;
    logic [DBYTES_W-1:0] rem_reg;
    logic [DBYTES_W-1:0] rem_next;
    logic [BUF_W-1:0]    pos_reg;
    logic [BUF_W-1:0]    pos_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    desc_t               out_desc_reg;
    desc_t               desc;
    logic                emit;
    logic                out_free;
    logic [CHUNK_W-1:0]  page_room;
    logic [DBYTES_W-1:0] chunk;

    assign out_valid = out_valid_reg;
    assign out_desc  = out_desc_reg;
    assign out_free  = !out_valid_reg || pop;

    // A page program stops at the next page boundary or at the end of the data.
    assign page_room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(addr_reg[PAGE_LG-1:0]);
    assign chunk     = (DBYTES_W'(page_room) > rem_reg) ? rem_reg : DBYTES_W'(page_room);

    always_comb
    begin
        state_next = state_reg;
        plan_next  = plan_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        desc       = '0;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    plan_next  = q_plan;
                    addr_next  = q_plan.addr;
                    rem_next   = q_plan.len;
                    pos_next   = q_plan.buf_base;
                    cnt_next   = q_plan.cnt;
                    state_next = q_plan.wake ? SEQ_WAKE : SEQ_BODY;
                end
            end
            SEQ_WAKE:
            begin
                desc.issue        = 1'b1;
                desc.opcode       = OPC_WAKE;
                desc.header_bytes = HDR_OPCODE;
                desc.last         = (plan_reg.kind == PLAN_NONE);
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = desc.last ? SEQ_IDLE : SEQ_BODY;
                end
            end
            SEQ_BODY:
            begin
                case (plan_reg.kind)
                    PLAN_READ:
                    begin
                        desc.issue        = 1'b1;
                        desc.opcode       = plan_reg.opcode;
                        desc.header_bytes = plan_reg.hdr;
                        desc.cmd_addr     = plan_reg.addr;
                        desc.data_dir     = DIR_READ;
                        desc.data_bytes   = plan_reg.len;
                        desc.buffer_pos   = plan_reg.buf_base;
                        desc.last         = 1'b1;
                    end
                    PLAN_WRITE:
                    begin
                        desc.issue        = 1'b1;
                        desc.poll_before  = 1'b1;
                        desc.write_enable = 1'b1;
                        desc.opcode       = OPC_PAGE_PROGRAM;
                        desc.header_bytes = HDR_ADDR;
                        desc.cmd_addr     = addr_reg;
                        desc.data_dir     = DIR_WRITE;
                        desc.data_bytes   = chunk;
                        desc.buffer_pos   = pos_reg;
                        desc.last         = (rem_reg == chunk);
                    end
                    PLAN_ERASE:
                    begin
                        desc.issue        = 1'b1;
                        desc.write_enable = 1'b1;
                        desc.opcode       = OPC_SECTOR_ERASE;
                        desc.header_bytes = HDR_ADDR;
                        desc.cmd_addr     = addr_reg;
                        desc.poll_after   = 1'b1;
                        desc.last         = (cnt_reg == CNT_W'(1));
                    end
                    PLAN_SLEEP:
                    begin
                        desc.issue        = 1'b1;
                        desc.poll_before  = 1'b1;
                        desc.opcode       = OPC_SLEEP;
                        desc.header_bytes = HDR_OPCODE;
                        desc.last         = 1'b1;
                    end
                    default:
                    begin
                        desc.status = plan_reg.status;
                        desc.last   = 1'b1;
                    end
                endcase
                if (out_free)
                begin
                    emit = 1'b1;
                    if (plan_reg.kind == PLAN_WRITE)
                    begin
                        addr_next = addr_reg + ADDR_W'(chunk);
                        pos_next  = pos_reg + BUF_W'(chunk);
                        rem_next  = rem_reg - chunk;
                    end
                    else if (plan_reg.kind == PLAN_ERASE)
                    begin
                        addr_next = addr_reg + ADDR_W'(SECTOR_BYTES);
                        cnt_next  = cnt_reg - 1'b1;
                    end
                    if (desc.last)
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        cnt_reg  <= cnt_next;
        if (emit)
        begin
            out_desc_reg <= desc;
        end
    end

endmodule

[test/tb_spi_flash_command_sequencer.sv]
// Self-checking testbench: random and directed flash requests against a local predictor.
module tb_spi_flash_command_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcs_pkg::*;

    // Operation code 7 is not used by the block, but the field allows it, so it is exercised.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_REQUESTS = 185;
    // The worst correct run stays below this limit, even a run made of nothing but
    // maximum-length writes against the slowest drain pattern.
    localparam int CYCLE_LIMIT     = 400000;
    // Two queued plans of up to 64 descriptors each may still be in flight after the last
    // expected descriptor, so the tail is watched for DRAIN_CYCLES after it.
    localparam int DRAIN_CYCLES    = 150;
    localparam int HOLD_AFTER      = 40;
    localparam int HOLD_CYCLES     = 600;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  count;
        logic [BUF_W-1:0]  buffer;
    } request_t;

    // Patterns that the descriptor sink cycles through.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_HALF,
        DRAIN_SLOW
    } drain_mode_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                push         = 1'b0;
    logic                pop          = 1'b0;
    logic [OP_W-1:0]     operation    = '0;
    logic [ADDR_W-1:0]   flash_addr   = '0;
    logic [LEN_W-1:0]    byte_count   = '0;
    logic [BUF_W-1:0]    buffer_addr  = '0;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;
    logic                issue;
    logic                poll_before;
    logic                write_enable;
    logic [OPC_W-1:0]    opcode;
    logic [HDR_W-1:0]    header_bytes;
    logic [ADDR_W-1:0]   cmd_addr;
    logic [DIR_W-1:0]    data_dir;
    logic [DBYTES_W-1:0] data_bytes;
    logic [BUF_W-1:0]    buffer_pos;
    logic                poll_after;
    logic                last;

    // Requests still to be offered, and descriptors the block owes us, oldest first.
    request_t pending_requests[$];
    desc_t    due_descriptors[$];
    request_t drive_req;

    // Predicted power state of the flash: it starts asleep after reset.
    logic        flash_awake      = 1'b0;
    int          mismatches       = 0;
    int          descriptors_seen = 0;
    int          accepted_count   = 0;
    int          cycle_count      = 0;
    int          burst_left       = 0;
    int          gap_left         = 0;
    int          drain_left       = 0;
    int          hold_left        = 0;
    logic        hold_done        = 1'b0;
    drain_mode_t drain_mode       = DRAIN_FREE;
    logic        receiver_hold;

    assign receiver_hold = (hold_left != 0);

    spi_flash_command_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .flash_addr   (flash_addr),
        .byte_count   (byte_count),
        .buffer_addr  (buffer_addr),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .issue        (issue),
        .poll_before  (poll_before),
        .write_enable (write_enable),
        .opcode       (opcode),
        .header_bytes (header_bytes),
        .cmd_addr     (cmd_addr),
        .data_dir     (data_dir),
        .data_bytes   (data_bytes),
        .buffer_pos   (buffer_pos),
        .poll_after   (poll_after),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A descriptor that sends nothing and only reports a status.
    function automatic desc_t refusal(logic [STATUS_W-1:0] code);
        desc_t d;
        d = '0;
        d.status = code;
        return d;
    endfunction

    // Expands one accepted request into the descriptors the block must emit, in order, and
    // advances the predicted power state. The body of the request is worked out first; the
    // wake command, where the request calls for one and the flash is asleep, is put in front.
    function automatic void expand_request(request_t r);
        desc_t             body[$];
        desc_t             d;
        logic              rouse;
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  l;
        logic [LEN_W-1:0]  rem;
        logic [LEN_W-1:0]  chunk;
        logic [BUF_W-1:0]  pos;
        int                sectors;

        rouse = 1'b0;
        d = '0;
        d.issue = 1'b1;
        case (r.op)
            OP_READ, OP_SFDP, OP_ID:
            begin
                d.opcode = OPC_READ;
                d.header_bytes = HDR_ADDR;
                a = r.addr;
                l = r.count;
                // SFDP always starts at address zero and carries a dummy byte; the ID read
                // always returns two bytes from address zero, whatever was asked.
                if (r.op == OP_SFDP)
                begin
                    d.opcode = OPC_READ_SFDP;
                    d.header_bytes = HDR_DUMMY;
                    a = '0;
                end
                if (r.op == OP_ID)
                begin
                    d.opcode = OPC_READ_ID;
                    a = '0;
                    l = LEN_W'(2);
                end
                if (l > MAX_LEN)
                    body.push_back(refusal(ST_TOO_LONG));
                else if (int'(a) + int'(l) > FLASH_BYTES)
                    body.push_back(refusal(ST_READ_RANGE));
                else
                begin
                    d.cmd_addr = a;
                    d.data_dir = DIR_READ;
                    d.data_bytes = DBYTES_W'(l);
                    d.buffer_pos = r.buffer;
                    body.push_back(d);
                    rouse = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (r.count > MAX_LEN)
                    body.push_back(refusal(ST_TOO_LONG));
                else if (r.count != '0)
                begin
                    d.poll_before = 1'b1;
                    d.write_enable = 1'b1;
                    d.opcode = OPC_PAGE_PROGRAM;
                    d.header_bytes = HDR_ADDR;
                    d.data_dir = DIR_WRITE;
                    a = r.addr;
                    pos = r.buffer;
                    rem = r.count;
                    // One page program per page-bounded chunk; flash and buffer addresses
                    // simply wrap at their widths.
                    while (rem != '0)
                    begin
                        chunk = LEN_W'(PAGE_BYTES) - (a & PAGE_MASK);
                        if (chunk > rem)
                            chunk = rem;
                        d.cmd_addr = a;
                        d.data_bytes = DBYTES_W'(chunk);
                        d.buffer_pos = pos;
                        body.push_back(d);
                        a = a + chunk;
                        pos = pos + BUF_W'(chunk);
                        rem = rem - chunk;
                    end
                    // A write that cannot fit in one run of descriptors, wake included, is
                    // refused as a whole and leaves the flash as it was.
                    if (body.size() + (flash_awake ? 0 : 1) > MAX_RESULTS)
                    begin
                        body.delete();
                        body.push_back(refusal(ST_TOO_LONG));
                    end
                    else
                        rouse = 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (r.count > MAX_LEN)
                    body.push_back(refusal(ST_TOO_LONG));
                else
                begin
                    // An erase wakes the flash even when its address turns out to be bad.
                    rouse = 1'b1;
                    if ((r.addr & SECTOR_MASK) != '0 ||
                        int'(r.addr) > FLASH_BYTES - SECTOR_BYTES)
                        body.push_back(refusal(ST_ERASE_BAD));
                    else
                    begin
                        d.write_enable = 1'b1;
                        d.opcode = OPC_SECTOR_ERASE;
                        d.header_bytes = HDR_ADDR;
                        d.poll_after = 1'b1;
                        a = r.addr;
                        sectors = (int'(r.count) + SECTOR_BYTES - 1) / SECTOR_BYTES;
                        for (int s = 0; s < sectors; s++)
                        begin
                            d.cmd_addr = a;
                            body.push_back(d);
                            a = a + ADDR_W'(SECTOR_BYTES);
                        end
                    end
                end
            end
            OP_SLEEP:
            begin
                if (flash_awake)
                begin
                    flash_awake = 1'b0;
                    d.poll_before = 1'b1;
                    d.opcode = OPC_SLEEP;
                    d.header_bytes = HDR_OPCODE;
                    body.push_back(d);
                end
            end
            OP_WAKE:
                rouse = 1'b1;
            default:
                ;
        endcase

        if (rouse && !flash_awake)
        begin
            flash_awake = 1'b1;
            d = '0;
            d.issue = 1'b1;
            d.opcode = OPC_WAKE;
            d.header_bytes = HDR_OPCODE;
            body.push_front(d);
        end
        // Every request ends in exactly one descriptor marked last, even when nothing is sent.
        if (body.size() == 0)
            body.push_back(refusal(ST_OK));
        d = body.pop_back();
        d.last = 1'b1;
        body.push_back(d);
        foreach (body[i])
            due_descriptors.push_back(body[i]);
    endfunction

    function automatic void check_field(string field, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("descriptor %0d, %s: expected 0x%0h, got 0x%0h",
                         descriptors_seen, field, want, got);
        end
    endfunction

    function automatic void add_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                        logic [LEN_W-1:0] count, logic [BUF_W-1:0] buffer);
        request_t r;
        r.op = op;
        r.addr = addr;
        r.count = count;
        r.buffer = buffer;
        pending_requests.push_back(r);
    endfunction

    // Mostly well-formed requests with random content, with a share of oversize,
    // out-of-range and misaligned ones mixed in.
    function automatic void add_random_request();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  count;

        pick = $urandom_range(0, 99);
        addr = ADDR_W'($urandom());
        count = LEN_W'($urandom_range(0, 64));
        if (pick < 22)
        begin
            op = OP_READ;
            if ($urandom_range(0, 6) == 0)
                count = LEN_W'($urandom());
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    count = LEN_W'($urandom_range(0, MAX_REQUEST_BYTES));
                // Otherwise the full-width address nearly always runs off the end.
                if ($urandom_range(0, 4) != 0)
                    addr = ADDR_W'($urandom_range(0, FLASH_BYTES - int'(count)));
            end
        end
        else if (pick < 28)
        begin
            op = OP_SFDP;
            if ($urandom_range(0, 5) == 0)
                count = LEN_W'($urandom_range(MAX_REQUEST_BYTES - 8, MAX_REQUEST_BYTES + 8));
        end
        else if (pick < 32)
            op = OP_ID;
        else if (pick < 60)
        begin
            op = OP_WRITE;
            case ($urandom_range(0, 19))
                0:       count = '0;
                1:       count = LEN_W'($urandom_range(MAX_REQUEST_BYTES + 1, 24'hFFFFFF));
                2, 3:    count = LEN_W'($urandom_range(1, MAX_REQUEST_BYTES));
                default: count = LEN_W'($urandom_range(1, 3 * PAGE_BYTES));
            endcase
        end
        else if (pick < 78)
        begin
            op = OP_ERASE;
            count = LEN_W'($urandom_range(0, MAX_REQUEST_BYTES));
            case ($urandom_range(0, 9))
                0:       count = LEN_W'($urandom_range(MAX_REQUEST_BYTES + 1, 24'hFFFFFF));
                1, 2:    ;
                default: addr = ADDR_W'($urandom_range(0, FLASH_BYTES / SECTOR_BYTES - 1)
                                         * SECTOR_BYTES);
            endcase
        end
        else if (pick < 87)
            op = OP_SLEEP;
        else if (pick < 96)
            op = OP_WAKE;
        else
            op = OP_UNUSED;
        add_request(op, addr, count, BUF_W'($urandom()));
    endfunction

    // Request driver. A new request goes on the ports whenever the previous transaction has
    // completed or the port is idle. It works in bursts of random length separated by
    // random gaps; a quarter of the gaps are empty, so long unbroken runs also occur. While
    // the sink is held off the gaps are skipped, so that the block is pushed until it stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || !full)
        begin
            if (gap_left != 0 && !receiver_hold)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                drive_req = pending_requests.pop_front();
                operation <= drive_req.op;
                flash_addr <= drive_req.addr;
                byte_count <= drive_req.count;
                buffer_addr <= drive_req.buffer;
                push <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                push <= 1'b0;
        end
    end

    // Descriptor sink. It switches between free-running, half-rate and slow draining at
    // random intervals, and pops nothing at all during the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            drain_mode <= DRAIN_FREE;
            drain_left <= 0;
        end
        else
        begin
            if (drain_left == 0)
            begin
                drain_mode <= drain_mode_t'($urandom_range(0, 2));
                drain_left <= $urandom_range(10, 200);
            end
            else
                drain_left <= drain_left - 1;

            if (receiver_hold)
                pop <= 1'b0;
            else
                case (drain_mode)
                    DRAIN_FREE: pop <= 1'b1;
                    DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
                    default:    pop <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // One long hold-off of the sink, started once a fair number of requests has gone in.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_count >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor. Both handshakes are sampled with the values that stood before the edge. An
    // accepted request transaction is expanded into expected descriptors first; an accepted
    // descriptor transaction is then compared field by field with the oldest expectation.
    always @(posedge clk)
    begin
        desc_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                expand_request(request_t'({operation, flash_addr, byte_count, buffer_addr}));
                accepted_count <= accepted_count + 1;
            end
            if (pop && !empty)
            begin
                if (due_descriptors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("descriptor %0d: none expected, got opcode 0x%0h status %0d",
                                 descriptors_seen, opcode, status);
                end
                else
                begin
                    want = due_descriptors.pop_front();
                    check_field("status", want.status, status);
                    check_field("issue", want.issue, issue);
                    check_field("poll_before", want.poll_before, poll_before);
                    check_field("write_enable", want.write_enable, write_enable);
                    check_field("opcode", want.opcode, opcode);
                    check_field("header_bytes", want.header_bytes, header_bytes);
                    check_field("cmd_addr", want.cmd_addr, cmd_addr);
                    check_field("data_dir", want.data_dir, data_dir);
                    check_field("data_bytes", want.data_bytes, data_bytes);
                    check_field("buffer_pos", want.buffer_pos, buffer_pos);
                    check_field("poll_after", want.poll_after, poll_after);
                    check_field("last", want.last, last);
                end
                descriptors_seen++;
            end
        end
    end

    // Watchdog: a run that never drains is a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d descriptors outstanding",
                     cycle_count, due_descriptors.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // Directed requests, starting with the flash asleep. They cover the power state
        // transitions, both ends of every field, the read range edge, a maximum-length
        // write across page boundaries that needs the full run of descriptors, address
        // wrap on a write, bad erase addresses, zero lengths and the unused operation.
        add_request(OP_READ, '0, '0, '0);
        add_request(OP_SLEEP, '0, '0, '0);
        add_request(OP_SLEEP, '0, '0, '0);
        add_request(OP_WAKE, '0, '0, '0);
        add_request(OP_WAKE, '0, '0, '0);
        add_request(OP_SLEEP, '0, '0, '0);
        add_request(OP_READ, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        add_request(OP_READ, ADDR_W'(FLASH_BYTES - 100), 24'd101, 16'h1234);
        add_request(OP_READ, ADDR_W'(FLASH_BYTES - 100), 24'd100, 16'hFFFF);
        add_request(OP_READ, '0, LEN_W'(MAX_REQUEST_BYTES + 1), '0);
        add_request(OP_READ, '0, MAX_LEN, 16'hFFFF);
        add_request(OP_SFDP, 24'hFFFFFF, MAX_LEN, 16'h8000);
        add_request(OP_SFDP, '0, LEN_W'(MAX_REQUEST_BYTES + 1), '0);
        add_request(OP_ID, 24'hFFFFFF, 24'hFFFFFF, 16'h00FF);
        add_request(OP_SLEEP, '0, '0, '0);
        add_request(OP_WRITE, 24'h0000FF, MAX_LEN, 16'hFFFF);
        add_request(OP_WRITE, 24'h000100, '0, 16'h0001);
        add_request(OP_WRITE, '0, LEN_W'(MAX_REQUEST_BYTES + 1), '0);
        add_request(OP_WRITE, 24'hFFFFF0, 24'd300, 16'hFFF0);
        add_request(OP_SLEEP, '0, '0, '0);
        add_request(OP_ERASE, 24'h000123, LEN_W'(SECTOR_BYTES), '0);
        add_request(OP_ERASE, ADDR_W'(FLASH_BYTES - SECTOR_BYTES), MAX_LEN, '0);
        add_request(OP_ERASE, ADDR_W'(FLASH_BYTES), 24'd1, '0);
        add_request(OP_ERASE, '0, '0, '0);
        add_request(OP_ERASE, '0, 24'hFFFFFF, '0);
        add_request(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        add_request(OP_ERASE, '0, 24'd1, '0);
        for (int i = 0; i < RANDOM_REQUESTS; i++)
            add_random_request();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Sampling on the falling edge keeps this wait clear of the monitor's updates.
        while (pending_requests.size() != 0 || push || due_descriptors.size() != 0)
            @(negedge clk);
        // Anything the block emits from here on is unexpected and is caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
